// ----- design/mpq_pkg.sv -----
package mpq_pkg;

    // queue geometry
    localparam int LEVELS  = 8;
    localparam int DEPTH   = 128;

    // field widths
    localparam int VALUE_W = 32;
    localparam int LVL_W   = 4;
    localparam int STAT_W  = 3;

    // fill count runs 0..DEPTH, slot address 0..DEPTH-1
    localparam int PTR_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_PRIO = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DELETED  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

    // command broadcast to every cell
    typedef struct packed {
        logic               go;
        logic               del;
        logic [LVL_W-1:0]   prio;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // data handed from one cell to the next
    typedef struct packed {
        logic               found;
        logic               full;
        logic [LVL_W-1:0]   lvl;
        logic [VALUE_W-1:0] data;
    } chain_t;

endpackage

// ----- design/mpq_cell.sv -----
module mpq_cell
    import mpq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [LVL_W-1:0] lvl_id,
    input  cmd_t             cmd,
    input  chain_t           chain_in,
    output chain_t           chain_out
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_reg;
    logic               sel_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]   head_inc;
    logic               nonempty;
    logic               match;
    logic               is_full;
    logic               ins;
    logic               take;

    // level status and this cell's share of the command
    assign nonempty = head_reg < fill_reg;
    assign match    = cmd.go && !cmd.del && (cmd.prio == lvl_id);
    assign is_full  = fill_reg == PTR_W'(DEPTH);
    assign ins      = match && !is_full;
    assign take     = cmd.go && cmd.del && !chain_in.found && nonempty;
    assign head_inc = head_reg + PTR_W'(1);

    // pointer update, level drains back to empty
    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ins) begin
            fill_next = fill_reg + PTR_W'(1);
        end else if (take) begin
            if (head_inc >= fill_reg) begin
                head_next = '0;
                fill_next = '0;
            end else begin
                head_next = head_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
            sel_reg  <= 1'b0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            sel_reg  <= take;
        end
    end

    // slot storage, registered read
    always_ff @(posedge aclk) begin
        if (ins) begin
            mem[fill_reg[ADDR_W-1:0]] <= cmd.value;
        end
        if (take) begin
            rd_reg <= mem[head_reg[ADDR_W-1:0]];
        end
    end

    // pass flags and fetched word toward the higher levels
    always_comb begin
        chain_out.found = chain_in.found | nonempty;
        chain_out.full  = chain_in.full | (match && is_full);
        chain_out.lvl   = sel_reg ? lvl_id : chain_in.lvl;
        chain_out.data  = sel_reg ? rd_reg : chain_in.data;
    end

endmodule

// ----- design/multilevel_priority_queue.sv -----
// multilevel priority queue, one linear fifo per level, level 0 most urgent
// input channel s_*: tuser is the operation (insert or delete), tdata holds
//   the value and the target level of an insert
// result channel m_*: one transfer per input item; tuser is the status,
//   tdata holds the removed value and its level (zero unless deleted)
// insert, bad level, level full and all-empty results are registered in the
//   cycle of the input transfer, one item per cycle unless m_tready stalls
// a delete reads the chosen level's slot memory (registered read) and the
//   word rides the cell chain to the output register in ST_FETCH; no new
//   item is taken until ST_FETCH has loaded the output register
// the level for a delete comes from a found flag rippling through the cells
// a level takes at most DEPTH inserts between two moments it is empty
// reset clears all level pointers, so every level starts empty; slot
//   memories are not cleared
// s_tready is low while a delete is being fetched and while a result waits
//   in the output register with m_tready low
module multilevel_priority_queue
    import mpq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // value[31:0], priority_req[35:32], zero[39:36]
    input  logic        s_tuser,  // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // out_value[31:0], out_level[35:32], zero[39:36]
    output logic [2:0]  m_tuser   // status[2:0]
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    logic [LVL_W-1:0]   m_level_reg, m_level_next;
    logic               s_accept;
    logic               bad_prio;
    cmd_t               cmd;
    chain_t             chain [LEVELS+1];

    // input side
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign bad_prio = {1'b0, s_tdata[35:32]} >= (LVL_W + 1)'(LEVELS);

    always_comb begin
        cmd.go    = s_accept;
        cmd.del   = s_tuser == FUNC_DELETE;
        cmd.prio  = s_tdata[35:32];
        cmd.value = s_tdata[31:0];
    end

    // row of level cells
    assign chain[0] = '0;

    for (genvar i = 0; i < LEVELS; i++) begin : g_cell
        mpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lvl_id    (LVL_W'(i)),
            .cmd       (cmd),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // sequencing and result register
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_level_next  = m_level_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    m_value_next = '0;
                    m_level_next = '0;
                    if (cmd.del) begin
                        if (chain[LEVELS].found) begin
                            state_next = ST_FETCH;
                        end else begin
                            m_valid_next  = 1'b1;
                            m_status_next = STAT_EMPTY;
                        end
                    end else begin
                        m_valid_next = 1'b1;
                        priority if (bad_prio) begin
                            m_status_next = STAT_BAD_PRIO;
                        end else if (chain[LEVELS].full) begin
                            m_status_next = STAT_FULL;
                        end else begin
                            m_status_next = STAT_INSERTED;
                        end
                    end
                end
            end
            ST_FETCH: begin
                m_valid_next  = 1'b1;
                m_status_next = STAT_DELETED;
                m_value_next  = chain[LEVELS].data;
                m_level_next  = chain[LEVELS].lvl;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_level_reg  <= m_level_next;
    end

    // result side
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0000, m_level_reg, m_value_reg};

endmodule
